>>> rtl/core/modbus_tcp_header_extractor_defines.svh
// ---------------------------------------------------------------------------
// Modbus/TCP header extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MODBUS_TCP_HEADER_EXTRACTOR_DEFINES_SVH
`define MODBUS_TCP_HEADER_EXTRACTOR_DEFINES_SVH

// Check that a property holds at every edge out of reset.
`define MBTCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds out of reset.
`define MBTCP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/mbtcp_pkg.sv
// ---------------------------------------------------------------------------
// Modbus/TCP header extractor package
// Frame offsets, register indexes, status codes and stream widths.
// ---------------------------------------------------------------------------
`default_nettype none

package mbtcp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65536;

    localparam int ETH_HEADER_BYTES = 14;
    localparam int IP_PROTO_OFFSET  = 23;
    localparam int SRC_IP_OFFSET    = 26;
    localparam int DST_IP_OFFSET    = 30;
    localparam int TCP_DOFF_OFFSET  = 12;
    localparam int MBAP_BYTES       = 7;
    localparam int PDU_KEEP         = 5;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] SERVICE_PORT_RST = 16'd502;
    localparam logic [7:0]  READ_FC_RST      = 8'd3;
    localparam logic [7:0]  WRITE_FC_RST     = 8'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SERVICE_PORT = 2'd0,
        REG_READ_FC      = 2'd1,
        REG_WRITE_FC     = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT_PDU = 2'd1;
    localparam logic [1:0] STATUS_SHORT_RW  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/modbus_tcp_header_extractor.sv
// ---------------------------------------------------------------------------
// Modbus/TCP header extractor
// Parses captured Ethernet frames byte by byte and reports IPv4 addresses,
// the Modbus function code, register address and value at frame end.
// ---------------------------------------------------------------------------
// The block takes one frame byte in every cycle; s_tready drops only while a
// finished result sits in the output register and m_tready is low. Each byte
// passes through one stage of offset compares against the running byte
// position, and the result of a frame appears on the master side in the cycle
// after its last byte is accepted. Frames that fail the TCP or port check, or
// carry no PDU byte after the MBAP header, give no result. No clearing pass
// follows reset; all frame state is in flip-flops.
`default_nettype none

module modbus_tcp_header_extractor #(
    parameter int MAX_FRAME_BYTES = mbtcp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // frame_byte [7:0], timestamp_ms [39:8]
    input  wire logic [mbtcp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // source_address [31:0], destination_address [63:32], function_code [71:64],
    // register_address [87:72], register_value [103:88], packet_time [135:104],
    // parse_status [137:136], zero fill above
    output logic [mbtcp_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mbtcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mbtcp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import mbtcp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    logic [15:0]      service_port_reg;
    logic [7:0]       read_fc_reg;
    logic [7:0]       write_fc_reg;

    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [3:0]       ihl_reg,       ihl_next;
    logic [3:0]       thw_reg,       thw_next;
    logic             is_tcp_reg,    is_tcp_next;
    logic [15:0]      sport_reg,     sport_next;
    logic [7:0]       dport_hi_reg,  dport_hi_next;
    logic             matched_reg,   matched_next;
    logic [31:0]      src_ip_reg,    src_ip_next;
    logic [31:0]      dst_ip_reg,    dst_ip_next;
    logic [7:0]       pdu_reg [PDU_KEEP];
    logic [7:0]       pdu_next [PDU_KEEP];
    logic [2:0]       cnt_reg,       cnt_next;

    logic             out_valid_reg;
    logic [31:0]      out_src_reg,   out_dst_reg,   out_time_reg;
    logic [7:0]       out_fc_reg;
    logic [15:0]      out_addr_reg,  out_val_reg;
    logic [1:0]       out_status_reg;

    logic             s_accept;
    logic             emit;
    logic [7:0]       byte_in;
    logic [CMP_W-1:0] p_ext;
    logic [CMP_W-1:0] tcp_start;
    logic [CMP_W-1:0] pdu_start;
    logic [7:0]       fc;
    logic [15:0]      addr;
    logic [15:0]      val;
    logic [1:0]       status;
    logic [31:0]      src_ip_fin;
    logic [31:0]      dst_ip_fin;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign byte_in  = s_tdata[7:0];
    assign p_ext    = CMP_W'(pos_reg);

    always_comb
    begin
        pos_next      = pos_reg;
        ihl_next      = ihl_reg;
        thw_next      = thw_reg;
        is_tcp_next   = is_tcp_reg;
        sport_next    = sport_reg;
        dport_hi_next = dport_hi_reg;
        matched_next  = matched_reg;
        src_ip_next   = src_ip_reg;
        dst_ip_next   = dst_ip_reg;
        pdu_next      = pdu_reg;
        cnt_next      = cnt_reg;
        tcp_start     = '0;
        pdu_start     = '0;
        emit          = 1'b0;
        fc            = '0;
        addr          = '0;
        val           = '0;
        status        = STATUS_OK;
        src_ip_fin    = '0;
        dst_ip_fin    = '0;
        if (s_accept)
        begin
            if (pos_reg < POS_W'(MAX_FRAME_BYTES))
            begin
                pos_next = pos_reg + 1'b1;
                if (p_ext == CMP_W'(ETH_HEADER_BYTES))
                begin
                    ihl_next = byte_in[3:0];
                end
                tcp_start = CMP_W'(ETH_HEADER_BYTES) + CMP_W'({ihl_next, 2'b00});
                if (p_ext == CMP_W'(IP_PROTO_OFFSET))
                begin
                    is_tcp_next = (byte_in == TCP_PROTOCOL);
                end
                case (p_ext)
                    CMP_W'(SRC_IP_OFFSET):     src_ip_next[31:24] = byte_in;
                    CMP_W'(SRC_IP_OFFSET + 1): src_ip_next[23:16] = byte_in;
                    CMP_W'(SRC_IP_OFFSET + 2): src_ip_next[15:8]  = byte_in;
                    CMP_W'(SRC_IP_OFFSET + 3): src_ip_next[7:0]   = byte_in;
                    CMP_W'(DST_IP_OFFSET):     dst_ip_next[31:24] = byte_in;
                    CMP_W'(DST_IP_OFFSET + 1): dst_ip_next[23:16] = byte_in;
                    CMP_W'(DST_IP_OFFSET + 2): dst_ip_next[15:8]  = byte_in;
                    CMP_W'(DST_IP_OFFSET + 3): dst_ip_next[7:0]   = byte_in;
                    default: ;
                endcase
                if (p_ext == tcp_start)
                begin
                    sport_next = {byte_in, 8'd0};
                end
                if (p_ext == tcp_start + CMP_W'(1))
                begin
                    sport_next[7:0] = byte_in;
                end
                if (p_ext == tcp_start + CMP_W'(2))
                begin
                    dport_hi_next = byte_in;
                end
                if (p_ext == tcp_start + CMP_W'(3))
                begin
                    matched_next = (sport_next == service_port_reg)
                                || ({dport_hi_next, byte_in} == service_port_reg);
                end
                if (p_ext == tcp_start + CMP_W'(TCP_DOFF_OFFSET))
                begin
                    thw_next = byte_in[7:4];
                end
                pdu_start = tcp_start + CMP_W'({thw_next, 2'b00}) + CMP_W'(MBAP_BYTES);
                if (thw_next >= 4'd2 && p_ext >= pdu_start
                    && cnt_reg < 3'(PDU_KEEP))
                begin
                    pdu_next[cnt_reg] = byte_in;
                    cnt_next          = cnt_reg + 3'd1;
                end
            end
            if (s_tlast)
            begin
                src_ip_fin = src_ip_next;
                dst_ip_fin = dst_ip_next;
                emit = is_tcp_next && matched_next && (thw_next >= 4'd2)
                    && (cnt_next != 3'd0);
                if (cnt_next < 3'd2)
                begin
                    status = STATUS_SHORT_PDU;
                end
                else
                begin
                    fc = pdu_next[0];
                    if (fc == read_fc_reg || fc == write_fc_reg)
                    begin
                        if (cnt_next >= 3'(PDU_KEEP))
                        begin
                            addr = {pdu_next[1], pdu_next[2]};
                            if (fc != read_fc_reg)
                            begin
                                val = {pdu_next[3], pdu_next[4]};
                            end
                        end
                        else
                        begin
                            status = STATUS_SHORT_RW;
                        end
                    end
                end
                pos_next      = '0;
                ihl_next      = '0;
                thw_next      = '0;
                is_tcp_next   = 1'b0;
                sport_next    = '0;
                dport_hi_next = '0;
                matched_next  = 1'b0;
                src_ip_next   = '0;
                dst_ip_next   = '0;
                cnt_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            service_port_reg <= SERVICE_PORT_RST;
            read_fc_reg      <= READ_FC_RST;
            write_fc_reg     <= WRITE_FC_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SERVICE_PORT: service_port_reg <= cfg_wdata;
                REG_READ_FC:      read_fc_reg      <= cfg_wdata[7:0];
                REG_WRITE_FC:     write_fc_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ihl_reg       <= '0;
            thw_reg       <= '0;
            is_tcp_reg    <= 1'b0;
            sport_reg     <= '0;
            dport_hi_reg  <= '0;
            matched_reg   <= 1'b0;
            src_ip_reg    <= '0;
            dst_ip_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            ihl_reg      <= ihl_next;
            thw_reg      <= thw_next;
            is_tcp_reg   <= is_tcp_next;
            sport_reg    <= sport_next;
            dport_hi_reg <= dport_hi_next;
            matched_reg  <= matched_next;
            src_ip_reg   <= src_ip_next;
            dst_ip_reg   <= dst_ip_next;
            cnt_reg      <= cnt_next;
            if (s_tready)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pdu_reg <= pdu_next;
        if (s_tready && emit)
        begin
            out_src_reg    <= src_ip_fin;
            out_dst_reg    <= dst_ip_fin;
            out_fc_reg     <= fc;
            out_addr_reg   <= addr;
            out_val_reg    <= val;
            out_time_reg   <= s_tdata[39:8];
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_time_reg, out_val_reg, out_addr_reg,
                       out_fc_reg, out_dst_reg, out_src_reg};

endmodule

`default_nettype wire

>>> rtl/core/mbtcp_checker.sv
// ---------------------------------------------------------------------------
// Modbus/TCP header extractor checker
// Port-level assertions on result timing and field consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modbus_tcp_header_extractor_defines.svh"

module mbtcp_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               s_tlast,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    // source_address [31:0], destination_address [63:32], function_code [71:64],
    // register_address [87:72], register_value [103:88], packet_time [135:104],
    // parse_status [137:136], zero fill above
    input wire logic [mbtcp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import mbtcp_pkg::*;

    `MBTCP_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `MBTCP_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
    `MBTCP_ASSERT(a_result_after_last, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast), "result without a frame end")
    `MBTCP_ASSERT_NEVER(a_status_code, m_tvalid && m_tdata[137:136] != STATUS_OK && m_tdata[137:136] != STATUS_SHORT_PDU && m_tdata[137:136] != STATUS_SHORT_RW, "undefined status")
    `MBTCP_ASSERT_NEVER(a_short_pdu_zero, m_tvalid && m_tdata[137:136] == STATUS_SHORT_PDU && m_tdata[103:64] != '0, "short PDU with nonzero fields")

endmodule

bind modbus_tcp_header_extractor mbtcp_checker u_mbtcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
